FILE: hdl/satlb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package satlb_pkg;

    localparam int PID_W      = 8;
    localparam int PAGE_W     = 20;
    localparam int FRAME_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 40;
    localparam int RECIP_W    = 32;
    localparam int RECIP_SHIFT = 31;

    localparam int DEFAULT_SETS = 16;
    localparam int DEFAULT_WAYS = 4;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic               valid;
        logic [PID_W-1:0]   proc_id;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } entry_t;

    typedef struct packed {
        logic clear_en;
        logic load;
        logic mul_en;
        logic rd_en;
        logic upd_en;
    } satlb_cmd_t;

    typedef struct packed {
        logic out_free;
    } satlb_sts_t;

endpackage

`default_nettype wire

FILE: hdl/satlb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module satlb_ctrl
    import satlb_pkg::*;
#(
    parameter int SETS  = DEFAULT_SETS,
    parameter int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire satlb_sts_t       sts,
    output satlb_cmd_t            cmd,
    output logic [SET_W-1:0]      clear_set
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_MUL    = 5'b00100,
        S_READ   = 5'b01000,
        S_UPDATE = 5'b10000
    } state_t;

    localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

    state_t           state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg, clr_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (clr_cnt_reg == LAST_SET) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                if (sts.out_free) begin
                    cmd.upd_en = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign clear_set = clr_cnt_reg;

endmodule

`default_nettype wire

FILE: hdl/satlb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module satlb_datapath
    import satlb_pkg::*;
#(
    parameter int SETS  = DEFAULT_SETS,
    parameter int WAYS  = DEFAULT_WAYS,
    parameter int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    output logic [FRAME_W-1:0]         m_tdata,
    output logic [STATUS_W-1:0]        m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire satlb_cmd_t            cmd,
    output satlb_sts_t                 sts,
    input  wire logic [SET_W-1:0]      clear_set
);

    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SETS_CW = $clog2(SETS + 1);
    localparam int PROD1_W = PAGE_W + RECIP_W;
    localparam int PROD2_W = PAGE_W + SETS_CW;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS));

    entry_t [WAYS-1:0] mem [SETS];

    op_t                 op_reg;
    logic [PID_W-1:0]    pid_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [PROD1_W-1:0]  prod1_reg;
    logic [PROD2_W-1:0]  prod2_reg;
    logic [SET_W-1:0]    set_reg;
    entry_t [WAYS-1:0]   row_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    status_t             status_reg;
    logic [FRAME_W-1:0]  frame_out_reg;

    logic [PAGE_W-1:0]   page_in;
    logic [PAGE_W-1:0]   quot;
    logic [PAGE_W-1:0]   rem;
    logic [PAGE_W-1:0]   rem_fix;
    logic [SET_W-1:0]    rd_set;

    logic                hit_any, mat_any, inv_any;
    logic [WAY_W-1:0]    hit_idx, mat_idx, inv_idx;
    entry_t [WAYS-1:0]   new_row;
    status_t             status_new;
    logic [FRAME_W-1:0]  frame_new;
    logic                row_changed;

    logic                mem_we;
    logic [SET_W-1:0]    wr_set;
    entry_t [WAYS-1:0]   wr_row;

    assign page_in = s_tdata[PID_W +: PAGE_W];
    assign quot    = prod1_reg[RECIP_SHIFT +: PAGE_W];
    assign rem     = page_reg - prod2_reg[PAGE_W-1:0];
    assign rem_fix = (rem >= PAGE_W'(SETS)) ? rem - PAGE_W'(SETS) : rem;
    assign rd_set  = rem_fix[SET_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= op_t'(s_tuser);
            pid_reg   <= s_tdata[PID_W-1:0];
            page_reg  <= page_in;
            frame_reg <= s_tdata[PID_W + PAGE_W +: FRAME_W];
            prod1_reg <= PROD1_W'(page_in) * PROD1_W'(RECIP);
        end
        if (cmd.mul_en) begin
            prod2_reg <= PROD2_W'(quot) * PROD2_W'(SETS);
        end
        if (cmd.rd_en) begin
            set_reg <= rd_set;
        end
    end

    always_comb begin
        hit_any = 1'b0;
        mat_any = 1'b0;
        inv_any = 1'b0;
        hit_idx = '0;
        mat_idx = '0;
        inv_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row_reg[w].proc_id == pid_reg && row_reg[w].page == page_reg) begin
                mat_any = 1'b1;
                mat_idx = WAY_W'(w);
                if (row_reg[w].valid) begin
                    hit_any = 1'b1;
                    hit_idx = WAY_W'(w);
                end
            end
            if (!row_reg[w].valid) begin
                inv_any = 1'b1;
                inv_idx = WAY_W'(w);
            end
        end
    end

    always_comb begin
        new_row     = row_reg;
        status_new  = STAT_MISS;
        frame_new   = '0;
        row_changed = 1'b0;
        case (op_reg)
            OP_LOOKUP: begin
                if (hit_any) begin
                    status_new = STAT_OK;
                    frame_new  = row_reg[hit_idx].frame;
                end
            end
            OP_WRITE: begin
                if (mat_any) begin
                    new_row[mat_idx].frame = frame_reg;
                    new_row[mat_idx].valid = 1'b1;
                    status_new  = STAT_OK;
                    row_changed = 1'b1;
                end else if (inv_any) begin
                    new_row[inv_idx] = '{valid: 1'b1, proc_id: pid_reg,
                                         page: page_reg, frame: frame_reg};
                    status_new  = STAT_OK;
                    row_changed = 1'b1;
                end else begin
                    status_new = STAT_FULL;
                end
            end
            default: begin
                status_new = STAT_MISS;
            end
        endcase
    end

    assign mem_we = cmd.clear_en | (cmd.upd_en & row_changed);
    assign wr_set = cmd.clear_en ? clear_set : set_reg;
    assign wr_row = cmd.clear_en ? '0 : new_row;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_set] <= wr_row;
        end
        if (cmd.rd_en) begin
            row_reg <= mem[rd_set];
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.upd_en) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd_en) begin
            status_reg    <= status_new;
            frame_out_reg <= frame_new;
        end
    end

    assign sts.out_free = ~m_tvalid_reg | m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tuser      = status_reg;
    assign m_tdata      = frame_out_reg;

endmodule

`default_nettype wire

FILE: hdl/set_assoc_tlb_lookup_update_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Ports                        Contents
// request   in   s_tvalid s_tready s_tdata    proc_id, page, frame_in; s_tuser = opcode
// result    out  m_tvalid m_tready m_tdata    frame_out; m_tuser = status
//
// Each request passes through request accept with set-index multiply, quotient
// multiply, set read from the entry memory, compare and write-back of the set row.
// The result sits in an output register; a stalled result holds the update step.
// After reset a clearing pass writes every set row to zero, with s_tready low.

module set_assoc_tlb_lookup_update_unit
    import satlb_pkg::*;
#(
    parameter int SETS = DEFAULT_SETS,
    parameter int WAYS = DEFAULT_WAYS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // proc_id[7:0], page[27:8], frame_in[35:28]
    input  wire logic                  s_tuser,  // opcode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [FRAME_W-1:0]         m_tdata,  // frame_out[7:0]
    output logic [STATUS_W-1:0]        m_tuser   // status[1:0]
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

    satlb_cmd_t       cmd;
    satlb_sts_t       sts;
    logic [SET_W-1:0] clear_set;

    satlb_ctrl #(
        .SETS  (SETS),
        .SET_W (SET_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sts       (sts),
        .cmd       (cmd),
        .clear_set (clear_set)
    );

    satlb_datapath #(
        .SETS  (SETS),
        .WAYS  (WAYS),
        .SET_W (SET_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .clear_set (clear_set)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous request in flight");

    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
        else $error("result appeared without a matching request");

    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("request taken before clearing pass");
`endif

endmodule

`default_nettype wire
